>>> rtl/ccpp_pkg.sv
// Shared types, codes and the CRC-8 step for the command packet parser.
// No dependencies; imported by the register block, the parser and the top level.
package ccpp_pkg;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h12;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h34;
  localparam logic [7:0] CRC_POLY        = 8'h07;

  // Packet type bytes
  localparam logic [7:0] TYPE_ROUTE     = 8'h01;
  localparam logic [7:0] TYPE_VERSION   = 8'h02;
  localparam logic [7:0] TYPE_POLL      = 8'h03;
  localparam logic [7:0] TYPE_STOP      = 8'h04;
  localparam logic [7:0] TYPE_DIRECTION = 8'h05;
  localparam logic [7:0] TYPE_WHEEL     = 8'h06;
  localparam logic [7:0] TYPE_CALIB     = 8'h07;
  localparam logic [7:0] TYPE_COMPANION = 8'h08;

  // Exact payload lengths, CRC byte included
  localparam logic [7:0] LEN_WHEEL     = 8'd9;
  localparam logic [7:0] LEN_COMPANION = 8'd10;
  localparam logic [7:0] LEN_ROUTE     = 8'd9;
  localparam logic [7:0] LEN_SHORT     = 8'd4;
  localparam logic [7:0] LEN_CALIB     = 8'd2;

  // Sub-code ranges
  localparam logic [7:0] DIR_MIN   = 8'd1;
  localparam logic [7:0] DIR_MAX   = 8'd6;
  localparam logic [7:0] CALIB_MIN = 8'd1;
  localparam logic [7:0] CALIB_MAX = 8'd2;

  // Result kinds
  localparam logic [2:0] KIND_WHEEL     = 3'd0;
  localparam logic [2:0] KIND_COMPANION = 3'd1;
  localparam logic [2:0] KIND_ROUTE     = 3'd2;
  localparam logic [2:0] KIND_STOP      = 3'd3;
  localparam logic [2:0] KIND_VERSION   = 3'd4;
  localparam logic [2:0] KIND_POLL      = 3'd5;
  localparam logic [2:0] KIND_DIRECTION = 3'd6;
  localparam logic [2:0] KIND_CALIB     = 3'd7;

  // Register indexes (paddr[2])
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  // Only payload bytes 0..8 are ever decoded; later bytes need no storage.
  localparam int STORE_BYTES = 9;
  localparam int STORE_IDX_W = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_TYPE,
    PH_LEN,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [7:0]  sub_code;
    logic        route_latched;
  } result_t;

  // One byte of CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/ccpp_cfg.sv
// APB-style register block holding the two sync header bytes.
// Depends on ccpp_pkg for the register indexes, reset values and cfg_t.
module ccpp_cfg
  import ccpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SYNC_FIRST_RST;
      cfg.sync_second <= SYNC_SECOND_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SYNC_FIRST:  cfg.sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Misaligned reads return zero
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_SYNC_FIRST:  prdata = {24'd0, cfg.sync_first};
        REG_SYNC_SECOND: prdata = {24'd0, cfg.sync_second};
        default:         prdata = '0;
      endcase
    end
  end

endmodule

>>> rtl/ccpp_parser.sv
// Header hunt, payload store, running CRC-8 and packet decode for one byte a cycle while step is high.
// Depends on ccpp_pkg for phase_t, cfg_t, result_t, codes and crc8_update.
module ccpp_parser
  import ccpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] byte_in,
  output logic       emit,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [7:0] packet_type, packet_type_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_crc, running_crc_next;
  logic       waypoint_pending, waypoint_pending_next;
  logic [7:0] store [STORE_BYTES];
  logic       store_we;

  logic [7:0]  len_eff;
  logic        last_byte;
  logic [31:0] word0, word1;

  assign len_eff   = (payload_length == 8'd0) ? 8'd1 : payload_length;
  assign last_byte = ({1'b0, payload_count} + 9'd1) >= {1'b0, len_eff};
  assign word0     = {store[3], store[2], store[1], store[0]};
  assign word1     = {store[7], store[6], store[5], store[4]};

  // Next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        PH_SYNC2: phase_next = (byte_in == cfg.sync_second) ? PH_TYPE : PH_SYNC1;
        PH_TYPE:  phase_next = PH_LEN;
        PH_LEN:   phase_next = PH_DATA;
        PH_DATA:  phase_next = last_byte ? PH_SYNC1 : PH_DATA;
        default:  phase_next = (byte_in == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
      endcase
    end
  end

  // Datapath updates and decode
  always_comb begin
    packet_type_next      = packet_type;
    payload_length_next   = payload_length;
    payload_count_next    = payload_count;
    running_crc_next      = running_crc;
    waypoint_pending_next = waypoint_pending;
    store_we              = 1'b0;
    emit                  = 1'b0;
    res                   = '0;
    if (step) begin
      unique case (phase)
        PH_TYPE: packet_type_next = byte_in;
        PH_LEN: begin
          payload_length_next = byte_in;
          payload_count_next  = 8'd0;
          running_crc_next    = 8'd0;
        end
        PH_DATA: begin
          store_we           = payload_count < 8'(STORE_BYTES);
          payload_count_next = payload_count + 8'd1;
          if (!last_byte) begin
            running_crc_next = crc8_update(running_crc, byte_in);
          end else if (byte_in == running_crc) begin
            unique case (packet_type)
              TYPE_WHEEL: if (len_eff == LEN_WHEEL) begin
                emit = 1'b1;
                res.kind = KIND_WHEEL;
                res.first_word = word0;
                res.second_word = word1;
              end
              TYPE_COMPANION: if (len_eff == LEN_COMPANION) begin
                emit = 1'b1;
                res.kind = KIND_COMPANION;
                res.first_word = word0;
                res.second_word = word1;
                res.sub_code = store[8];
              end
              TYPE_ROUTE: if (len_eff == LEN_ROUTE) begin
                emit = 1'b1;
                res.kind = KIND_ROUTE;
                res.first_word = word0;
                res.second_word = word1;
                res.route_latched = !waypoint_pending;
                waypoint_pending_next = 1'b1;
              end
              TYPE_STOP: if (len_eff == LEN_SHORT) begin
                emit = 1'b1;
                res.kind = KIND_STOP;
                waypoint_pending_next = 1'b0;
              end
              TYPE_VERSION: if (len_eff == LEN_SHORT) begin
                emit = 1'b1;
                res.kind = KIND_VERSION;
              end
              TYPE_POLL: if (len_eff == LEN_SHORT) begin
                emit = 1'b1;
                res.kind = KIND_POLL;
              end
              TYPE_DIRECTION: if (len_eff == LEN_SHORT && store[0] >= DIR_MIN &&
                                  store[0] <= DIR_MAX) begin
                emit = 1'b1;
                res.kind = KIND_DIRECTION;
                res.sub_code = store[0];
              end
              TYPE_CALIB: if (len_eff == LEN_CALIB && store[0] >= CALIB_MIN &&
                              store[0] <= CALIB_MAX) begin
                emit = 1'b1;
                res.kind = KIND_CALIB;
                res.sub_code = store[0];
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SYNC1;
      packet_type      <= '0;
      payload_length   <= '0;
      payload_count    <= '0;
      running_crc      <= '0;
      waypoint_pending <= 1'b0;
    end else begin
      phase            <= phase_next;
      packet_type      <= packet_type_next;
      payload_length   <= payload_length_next;
      payload_count    <= payload_count_next;
      running_crc      <= running_crc_next;
      waypoint_pending <= waypoint_pending_next;
    end
  end

  // Payload bytes past the decoded window are dropped
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[payload_count[STORE_IDX_W-1:0]] <= byte_in;
    end
  end

endmodule

>>> rtl/crc8_command_packet_parser_top.sv
// Top level of the sync-header CRC-8 command packet parser.
// A result word passes the input register and then the result register after its last byte is accepted.
// Throughput: one byte per cycle while no result word stalls; the running CRC register closes its loop.
// rx_ready drops only while a result word waits and the input register is full.
// Reset (rst, synchronous): parser returns to sync hunt, CRC, counts and waypoint mark
// clear, sync registers reload 0x12 and 0x34; the payload store is not cleared.
module crc8_command_packet_parser_top
  import ccpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic [31:0] first_word,
  output logic [31:0] second_word,
  output logic [7:0]  sub_code,
  output logic        route_latched,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       in_valid;   // input register holds a byte
  logic [7:0] in_byte;
  logic       advance;    // the held byte is processed this cycle
  logic       emit;
  result_t    res;

  ccpp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held byte whenever the result register is free or being emptied
  assign advance  = in_valid && (!result_valid || result_ready);
  assign rx_ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      in_byte <= rx_byte;
    end
  end

  ccpp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .byte_in (in_byte),
    .emit    (emit),
    .res     (res)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      kind          <= res.kind;
      first_word    <= res.first_word;
      second_word   <= res.second_word;
      sub_code      <= res.sub_code;
      route_latched <= res.route_latched;
    end
  end

endmodule

>>> rtl/ccpp_checker.sv
// Port-level checks for the command packet parser, bound to the top level.
// Depends on ccpp_pkg for the kind codes and sub-code ranges.
module ccpp_checker
  import ccpp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rx_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [2:0]  kind,
  input logic [31:0] first_word,
  input logic [31:0] second_word,
  input logic [7:0]  sub_code,
  input logic        route_latched
);

  // A stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(kind) &&
      $stable(first_word) && $stable(second_word) && $stable(sub_code) &&
      $stable(route_latched))
    else $error("result word changed while stalled");

  // Input back-pressure only comes from a waiting result word
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> result_valid && !result_ready)
    else $error("rx_ready low without a stalled result");

  // Only wheel, companion and route carry words or the latch mark
  a_words_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != KIND_WHEEL && kind != KIND_COMPANION && kind != KIND_ROUTE
      |-> first_word == 32'd0 && second_word == 32'd0 && !route_latched)
    else $error("words or latch mark set for a short packet kind");

  // Emitted sub-codes stay in their legal ranges
  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (kind != KIND_DIRECTION || (sub_code >= DIR_MIN && sub_code <= DIR_MAX)) &&
      (kind != KIND_CALIB || (sub_code >= CALIB_MIN && sub_code <= CALIB_MAX)))
    else $error("sub-code out of range");

endmodule

bind crc8_command_packet_parser_top ccpp_checker u_ccpp_checker (.*);
